/* hw/rtl/tdis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdis_pkg
// Shared types, sizes and codes of the task dispatcher with idle worker stack.
// ----------------------------------------------------------------------------
package tdis_pkg;

  // pool and queue sizes
  localparam int MaxWorkers      = 16;
  localparam int QueueDepth      = 64;
  localparam int WorkerCountRst  = 8;
  localparam int TaskW           = 16;
  localparam int WidW            = $clog2(MaxWorkers + 1);
  localparam int StkIdxW         = $clog2(MaxWorkers);
  localparam int QIdxW           = $clog2(QueueDepth);
  localparam int QCntW           = $clog2(QueueDepth + 1);

  // register index of worker_count on the config port
  localparam logic RegWorkerCount = 1'b0;

  typedef enum logic [2:0] {
    ST_DISPATCHED = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_IDLED      = 3'd2,
    ST_FULL       = 3'd3,
    ST_BADWORKER  = 3'd4
  } status_e;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic {
    BK_RUN,
    BK_READ
  } back_state_e;

  // input word
  typedef struct packed {
    logic             operation;
    logic [TaskW-1:0] task_id;
    logic             high_priority;
    logic [4:0]       worker_id;
  } item_t;

  // result word
  typedef struct packed {
    status_e          status;
    logic [4:0]       assigned_worker;
    logic [TaskW-1:0] assigned_task;
    logic [4:0]       idle_workers;
    logic [6:0]       waiting_tasks;
  } result_t;

  // classified command between front and back
  typedef struct packed {
    op_e                op;
    logic [TaskW-1:0]   task_id;
    logic               high;
    logic               wid_ok;
    logic [StkIdxW-1:0] widx;
    logic [WidW-1:0]    wid;
  } cmd_t;

  // pool rebuild request from the config port
  typedef struct packed {
    logic            rebuild;
    logic [WidW-1:0] count;
  } cfg_t;

  // worker count as the pool uses it: zero acts as one, clipped at the pool size
  function automatic logic [WidW-1:0] eff_count(input logic [4:0] raw);
    logic [WidW-1:0] n;
    n = WidW'(raw);
    if (raw == 5'd0) begin
      n = WidW'(1);
    end else if (WidW'(raw) > WidW'(MaxWorkers)) begin
      n = WidW'(MaxWorkers);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/tdis_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdis_front
// Accepts request words and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module tdis_front import tdis_pkg::*; (
  input  logic  start_i,
  input  item_t item_i,
  input  logic  full_i,
  output logic  push_o,
  output logic  busy_o,
  output cmd_t  cmd_o
);

  logic [WidW-1:0] wid_m1;

  // accept while the command queue has room
  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

  // decode the word and range-check the worker id
  always_comb begin
    wid_m1         = WidW'(item_i.worker_id) - WidW'(1);
    cmd_o.op       = item_i.operation ? OP_FINISH : OP_SUBMIT;
    cmd_o.task_id  = item_i.task_id;
    cmd_o.high     = item_i.high_priority;
    cmd_o.wid      = WidW'(item_i.worker_id);
    cmd_o.widx     = wid_m1[StkIdxW-1:0];
    cmd_o.wid_ok   = (item_i.worker_id != 5'd0) &&
                     (WidW'(item_i.worker_id) <= WidW'(MaxWorkers));
  end

endmodule

/* hw/rtl/tdis_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdis_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tdis_cmd_fifo import tdis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cmd_o   = slot_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* hw/rtl/tdis_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdis_back
// Carries out commands: idle worker stack, wait deque, busy map, result word.
// ----------------------------------------------------------------------------
module tdis_back import tdis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    strobe_o,
  output result_t result_o
);

  back_state_e        state_q, state_d;
  logic [WidW-1:0]    stack_q [MaxWorkers];
  logic [WidW-1:0]    top_q, top_d;
  logic [QIdxW-1:0]   head_q, head_d;
  logic [QCntW-1:0]   fill_q, fill_d;
  logic [MaxWorkers-1:0] busy_q, busy_d;
  logic [WidW-1:0]    rwid_q, rwid_d;
  result_t            res_q, res_d;
  logic               strobe_q, strobe_d;

  // wait deque storage
  logic [TaskW-1:0]   mem [QueueDepth];
  logic [TaskW-1:0]   rdata_q;
  logic               mem_we, mem_re;
  logic [QIdxW-1:0]   mem_waddr;

  // stack write port
  logic               stk_we;
  logic [StkIdxW-1:0] stk_waddr;

  logic [WidW-1:0]    top_m1;
  logic [WidW-1:0]    pop_w;
  logic [WidW-1:0]    pop_wm1;
  logic [QCntW-1:0]   tail_sum;

  assign strobe_o = strobe_q;
  assign result_o = res_q;

  // next state, deque and stack control, result word
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    head_d    = head_q;
    fill_d    = fill_q;
    busy_d    = busy_q;
    rwid_d    = rwid_q;
    res_d     = res_q;
    strobe_d  = 1'b0;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = head_q;
    stk_we    = 1'b0;
    stk_waddr = top_q[StkIdxW-1:0];
    top_m1    = top_q - WidW'(1);
    pop_w     = stack_q[top_m1[StkIdxW-1:0]];
    pop_wm1   = pop_w - WidW'(1);
    tail_sum  = QCntW'(head_q) + fill_q;
    if (tail_sum >= QCntW'(QueueDepth)) begin
      tail_sum = tail_sum - QCntW'(QueueDepth);
    end

    if (cfg_i.rebuild) begin
      top_d   = cfg_i.count;
      head_d  = '0;
      fill_d  = '0;
      busy_d  = '0;
      state_d = BK_RUN;
    end else begin
      case (state_q)
        BK_RUN: begin
          if (valid_i) begin
            pop_o                 = 1'b1;
            strobe_d              = 1'b1;
            res_d.assigned_worker = '0;
            res_d.assigned_task   = '0;
            if (cmd_i.op == OP_SUBMIT) begin
              if (top_q != '0) begin
                // hand the task to the top idle worker
                top_d                           = top_m1;
                busy_d[pop_wm1[StkIdxW-1:0]]    = 1'b1;
                res_d.status                    = ST_DISPATCHED;
                res_d.assigned_worker           = 5'(pop_w);
                res_d.assigned_task             = cmd_i.task_id;
              end else if (fill_q == QCntW'(QueueDepth)) begin
                res_d.status = ST_FULL;
              end else begin
                // queue at front or back of the deque
                mem_we = 1'b1;
                if (cmd_i.high) begin
                  if (head_q == '0) begin
                    head_d = QIdxW'(QueueDepth - 1);
                  end else begin
                    head_d = head_q - QIdxW'(1);
                  end
                  mem_waddr = head_d;
                end else begin
                  mem_waddr = tail_sum[QIdxW-1:0];
                end
                fill_d       = fill_q + QCntW'(1);
                res_d.status = ST_QUEUED;
              end
            end else begin
              if (!cmd_i.wid_ok || !busy_q[cmd_i.widx]) begin
                res_d.status = ST_BADWORKER;
              end else if (fill_q != '0) begin
                // pull the front waiting task, result after the read
                mem_re = 1'b1;
                if (head_q == QIdxW'(QueueDepth - 1)) begin
                  head_d = '0;
                end else begin
                  head_d = head_q + QIdxW'(1);
                end
                fill_d   = fill_q - QCntW'(1);
                rwid_d   = cmd_i.wid;
                strobe_d = 1'b0;
                state_d  = BK_READ;
              end else begin
                // worker goes back on the idle stack
                if (top_q < WidW'(MaxWorkers)) begin
                  stk_we = 1'b1;
                  top_d  = top_q + WidW'(1);
                end
                busy_d[cmd_i.widx] = 1'b0;
                res_d.status       = ST_IDLED;
              end
            end
            res_d.idle_workers  = 5'(top_d);
            res_d.waiting_tasks = 7'(fill_d);
          end
        end
        BK_READ: begin
          strobe_d              = 1'b1;
          res_d.status          = ST_DISPATCHED;
          res_d.assigned_worker = 5'(rwid_q);
          res_d.assigned_task   = rdata_q;
          res_d.idle_workers    = 5'(top_q);
          res_d.waiting_tasks   = 7'(fill_q);
          state_d               = BK_RUN;
        end
        default: begin
          state_d = BK_RUN;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_RUN;
      top_q    <= WidW'(WorkerCountRst);
      head_q   <= '0;
      fill_q   <= '0;
      busy_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      busy_q   <= busy_d;
      strobe_q <= strobe_d;
    end
  end

  // idle stack, refilled with ids 1 upward on reset and on rebuild
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxWorkers; i++) begin
        stack_q[i] <= WidW'(i + 1);
      end
    end else if (cfg_i.rebuild) begin
      for (int i = 0; i < MaxWorkers; i++) begin
        stack_q[i] <= WidW'(i + 1);
      end
    end else if (stk_we) begin
      stack_q[stk_waddr] <= cmd_i.wid;
    end
  end

  // result word and pending worker id
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    rwid_q <= rwid_d;
  end

  // deque memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_i.task_id;
    end
    if (mem_re) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

/* hw/rtl/task_dispatcher_idle_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_dispatcher_idle_stack
// Dispatches tasks to a worker pool with an idle stack and a priority deque.
// ----------------------------------------------------------------------------
// A request word is taken on a clock edge with start high and busy low, and
// its result appears on result_o with strobe_o high for one cycle; the
// receiver cannot stall. Most words give their result in the cycle after
// the back end picks them up; a finish that pulls a waiting task passes
// the registered deque read port and BK_READ first. A two-entry command
// queue sits between the front and the back end, so busy rises only when
// that queue is full; rate is one word per cycle except for deque pulls
// and worker_count writes. Writing worker_count rebuilds the pool at once:
// idle stack refilled, busy map cleared, deque emptied. The user must write
// it only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module task_dispatcher_idle_stack import tdis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        strobe_o,
  output result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] wcount_q, wcount_d;
  logic       reg_hit;
  logic       cfg_wr;
  cfg_t       cfg;
  cmd_t       front_cmd;
  cmd_t       fifo_cmd;
  logic       push;
  logic       pop;
  logic       fifo_valid;
  logic       fifo_full;

  // config port
  assign pready   = 1'b1;
  assign reg_hit  = (paddr[2] == RegWorkerCount);
  assign cfg_wr   = psel & penable & pwrite & reg_hit;
  assign wcount_d = cfg_wr ? pwdata[4:0] : wcount_q;
  assign prdata   = reg_hit ? {27'd0, wcount_q} : 32'd0;

  always_comb begin
    cfg.rebuild = cfg_wr;
    cfg.count   = eff_count(pwdata[4:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= 5'(WorkerCountRst);
    end else begin
      wcount_q <= wcount_d;
    end
  end

  tdis_front u_front (
    .start_i (start),
    .item_i  (item_i),
    .full_i  (fifo_full),
    .push_o  (push),
    .busy_o  (busy),
    .cmd_o   (front_cmd)
  );

  tdis_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .full_o  (fifo_full),
    .cmd_o   (fifo_cmd)
  );

  tdis_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (fifo_valid),
    .cmd_i    (fifo_cmd),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule
